### design/ffra_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the first-fit region allocator.
// No dependencies.
package ffra_pkg;

    localparam int RAW_W  = 36;
    localparam int ADDR_W = 32;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_SHAPE = 3'd1;
    localparam logic [2:0] ERR_SLOT  = 3'd2;
    localparam logic [2:0] ERR_SPACE = 3'd3;
    localparam logic [2:0] ERR_LIVE  = 3'd4;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIT,
        ST_SCAN,
        ST_INS,
        ST_RSCAN,
        ST_REM
    } ffra_state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } ffra_op_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] size;
    } ffra_blk_t;

    typedef struct packed {
        ffra_op_t          op;
        logic [RAW_W-1:0]  req_size;
        logic [ADDR_W-1:0] pool;
    } ffra_cmd_t;

endpackage

### design/ffra_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffra_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/ffra_ceil.sv
`timescale 1ns / 1ps
// Round-up of a byte count to a multiple of the alignment by add and mask.
// ALIGN_BYTES must be a power of two; the block does not check it. Depends on ffra_pkg.
module ffra_ceil #(
    parameter int ALIGN_BYTES = 512
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ffra_pkg::RAW_W-1:0] raw,
    output logic                      done,
    output logic [ffra_pkg::RAW_W-1:0] size
);
    import ffra_pkg::*;

    localparam logic [RAW_W-1:0] ALIGN_MASK = RAW_W'(ALIGN_BYTES - 1);

    logic [RAW_W-1:0] size_reg;
    logic [RAW_W-1:0] size_next;
    logic             done_reg;

    assign size_next = (raw + ALIGN_MASK) & ~ALIGN_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            size_reg <= size_next;
        end
    end

    assign done = done_reg;
    assign size = size_reg;

endmodule

### design/ffra_cell.sv
`timescale 1ns / 1ps
// One cell of the address-ordered chain of live blocks.
// Depends on ffra_pkg.
module ffra_cell #(
    parameter int IDX = 0,
    parameter int SW  = 6,
    parameter int CW  = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ffra_pkg::ffra_cmd_t          cmd,
    input  logic [SW-1:0]                pos,
    input  logic [CW-1:0]                req_slot,
    input  logic [ffra_pkg::ADDR_W-1:0]  prev_end,
    input  ffra_pkg::ffra_blk_t          left_blk,
    input  logic [SW-1:0]                left_slot,
    input  ffra_pkg::ffra_blk_t          right_blk,
    input  logic [SW-1:0]                right_slot,
    input  ffra_pkg::ffra_blk_t          new_blk,
    input  logic [SW-1:0]                new_slot,
    output ffra_pkg::ffra_blk_t          blk,
    output logic [SW-1:0]                slot,
    output logic [ffra_pkg::ADDR_W-1:0]  end_addr,
    output logic                         fit,
    output logic                         match
);
    import ffra_pkg::*;

    localparam logic [SW-1:0] MY_IDX = SW'(IDX);

    ffra_blk_t         blk_reg;
    ffra_blk_t         blk_next;
    logic [SW-1:0]     slot_reg;
    logic [SW-1:0]     slot_next;
    logic              fit_reg;
    logic              fit_next;
    logic [ADDR_W-1:0] base;

    always_comb
    begin
        base = blk_reg.valid ? blk_reg.offset : cmd.pool;
        if (base >= prev_end)
        begin
            fit_next = RAW_W'(base - prev_end) >= cmd.req_size;
        end
        else
        begin
            fit_next = blk_reg.valid && (cmd.req_size == '0);
        end
    end

    always_comb
    begin
        blk_next  = blk_reg;
        slot_next = slot_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (MY_IDX > pos)
                begin
                    blk_next  = left_blk;
                    slot_next = left_slot;
                end
                else if (MY_IDX == pos)
                begin
                    blk_next  = new_blk;
                    slot_next = new_slot;
                end
            end
            OP_REMOVE:
            begin
                if (MY_IDX >= pos)
                begin
                    blk_next  = right_blk;
                    slot_next = right_slot;
                end
            end
            default:
            begin
                blk_next  = blk_reg;
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg <= '0;
        end
        else
        begin
            blk_reg <= blk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        fit_reg  <= fit_next;
    end

    assign blk      = blk_reg;
    assign slot     = slot_reg;
    assign end_addr = blk_reg.offset + blk_reg.size;
    assign fit      = fit_reg;
    assign match    = blk_reg.valid && (CW'(slot_reg) == req_slot);

endmodule

### design/first_fit_region_allocator.sv
`timescale 1ns / 1ps
// First-fit region allocator: a chain of cells holds the live blocks in address order.
// Depends on ffra_pkg, ffra_ram, ffra_ceil and ffra_cell.
//
// A request is taken when start is high and busy is low; its one result shows on
// the result ports for a single cycle with done high and cannot be held off. An
// allocation goes through alignment round-up, a step that settles the chain's fit
// flags, a first-fit scan that visits the chain cells one at a time (up to
// SLOT_COUNT) and an insert. A release scans the chain for the slot, one cell per
// cycle, then removes it. The result shows in the first cycle after busy falls,
// and a new request can be taken in that same cycle. An empty shape or an empty
// free-slot queue is answered in the next cycle without raising busy. The chain scan
// sets the rate. ALIGN_BYTES must be a power of two.
module first_fit_region_allocator #(
    parameter int SLOT_COUNT  = 64,
    parameter int ALIGN_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic        has_shape,
    input  logic [31:0] element_count,
    input  logic [3:0]  element_bytes,
    input  logic [5:0]  release_slot,
    output logic        done,
    output logic        ok,
    output logic [2:0]  error_code,
    output logic [5:0]  slot,
    output logic [31:0] offset,
    output logic [31:0] block_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import ffra_pkg::*;

    localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW    = (SW > 6) ? SW : 6;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [SW-1:0]    LAST_IDX = SW'(SLOT_COUNT - 1);
    localparam logic [CNT_W:0]   N_WIDE   = (CNT_W + 1)'(SLOT_COUNT);
    localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(SLOT_COUNT);

    ffra_state_t       state_reg, state_next;
    logic [SW-1:0]     k_reg, k_next;
    logic [SW-1:0]     pos_reg, pos_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [RAW_W-1:0]  size_reg, size_next;
    logic [CW-1:0]     req_slot_reg, req_slot_next;
    logic [5:0]        rel_slot_reg, rel_slot_next;
    logic [SW-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [ADDR_W-1:0] pool_reg;
    logic [SLOT_COUNT-1:0] written_reg, written_next;
    logic              head_wr_reg;
    logic [SW-1:0]     head_addr_reg;
    logic              done_reg, done_next;
    logic              ok_reg, ok_next;
    logic [2:0]        err_reg, err_next;
    logic [5:0]        slot_out_reg, slot_out_next;
    logic [31:0]       offset_reg, offset_next;
    logic [31:0]       bytes_reg, bytes_next;

    logic              div_start;
    logic              div_done;
    logic [RAW_W-1:0]  div_size;
    logic [RAW_W-1:0]  raw_bytes;

    logic              ram_we;
    logic [SW-1:0]     tail_addr;
    logic [CNT_W:0]    tail_sum;
    logic [SW-1:0]     ram_rdata;
    logic [SW-1:0]     head_slot;
    logic [SW-1:0]     k_prev;

    ffra_cmd_t         cmd;
    ffra_blk_t         new_blk;
    ffra_blk_t         blk_q [SLOT_COUNT];
    logic [SW-1:0]     slot_q [SLOT_COUNT];
    logic [ADDR_W-1:0] end_q [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] fit_q;
    logic [SLOT_COUNT-1:0] match_q;

    assign raw_bytes = RAW_W'(element_count) * RAW_W'(element_bytes);

    ffra_ceil #(
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_ceil (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .raw  (raw_bytes),
        .done (div_done),
        .size (div_size)
    );

    assign tail_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(free_cnt_reg);
    assign tail_addr = (tail_sum >= N_WIDE) ? SW'(tail_sum - N_WIDE) : SW'(tail_sum);

    ffra_ram #(
        .WIDTH(SW),
        .DEPTH(SLOT_COUNT)
    ) u_fifo_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tail_addr),
        .wdata(req_slot_reg[SW-1:0]),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    assign head_slot = head_wr_reg ? ram_rdata : head_addr_reg;
    assign k_prev    = k_reg - 1'b1;

    assign new_blk = '{valid: 1'b1, offset: cursor_reg, size: size_reg[ADDR_W-1:0]};

    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++)
        begin : g_cell
            ffra_blk_t         left_b;
            logic [SW-1:0]     left_s;
            ffra_blk_t         right_b;
            logic [SW-1:0]     right_s;
            logic [ADDR_W-1:0] prev_e;

            if (gi == 0)
            begin : g_first
                assign left_b = '0;
                assign left_s = '0;
                assign prev_e = '0;
            end
            else
            begin : g_mid
                assign left_b = blk_q[gi-1];
                assign left_s = slot_q[gi-1];
                assign prev_e = end_q[gi-1];
            end

            if (gi == SLOT_COUNT - 1)
            begin : g_last
                assign right_b = '0;
                assign right_s = '0;
            end
            else
            begin : g_inner
                assign right_b = blk_q[gi+1];
                assign right_s = slot_q[gi+1];
            end

            ffra_cell #(
                .IDX(gi),
                .SW (SW),
                .CW (CW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .pos       (pos_reg),
                .req_slot  (req_slot_reg),
                .prev_end  (prev_e),
                .left_blk  (left_b),
                .left_slot (left_s),
                .right_blk (right_b),
                .right_slot(right_s),
                .new_blk   (new_blk),
                .new_slot  (head_slot),
                .blk       (blk_q[gi]),
                .slot      (slot_q[gi]),
                .end_addr  (end_q[gi]),
                .fit       (fit_q[gi]),
                .match     (match_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        cursor_next   = cursor_reg;
        size_next     = size_reg;
        req_slot_next = req_slot_reg;
        rel_slot_next = rel_slot_reg;
        head_next     = head_reg;
        free_cnt_next = free_cnt_reg;
        written_next  = written_reg;
        done_next     = 1'b0;
        ok_next       = ok_reg;
        err_next      = err_reg;
        slot_out_next = slot_out_reg;
        offset_next   = offset_reg;
        bytes_next    = bytes_reg;
        div_start     = 1'b0;
        ram_we        = 1'b0;
        cmd.op        = OP_HOLD;
        cmd.req_size  = size_reg;
        cmd.pool      = pool_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_RELEASE)
                    begin
                        req_slot_next = CW'(release_slot);
                        rel_slot_next = release_slot;
                        k_next        = '0;
                        state_next    = ST_RSCAN;
                    end
                    else if (!has_shape || free_cnt_reg == '0)
                    begin
                        done_next     = 1'b1;
                        ok_next       = 1'b0;
                        err_next      = !has_shape ? ERR_SHAPE : ERR_SLOT;
                        slot_out_next = '0;
                        offset_next   = '0;
                        bytes_next    = '0;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    size_next  = div_size;
                    state_next = ST_FIT;
                end
            end
            ST_FIT:
            begin
                k_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (fit_q[k_reg])
                begin
                    pos_next    = k_reg;
                    cursor_next = (k_reg == '0) ? '0 : end_q[k_prev];
                    state_next  = ST_INS;
                end
                else if (!blk_q[k_reg].valid || k_reg == LAST_IDX)
                begin
                    done_next     = 1'b1;
                    ok_next       = 1'b0;
                    err_next      = ERR_SPACE;
                    slot_out_next = '0;
                    offset_next   = '0;
                    bytes_next    = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_INS:
            begin
                cmd.op        = OP_INSERT;
                head_next     = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                free_cnt_next = free_cnt_reg - 1'b1;
                done_next     = 1'b1;
                ok_next       = 1'b1;
                err_next      = ERR_NONE;
                slot_out_next = 6'(head_slot);
                offset_next   = cursor_reg;
                bytes_next    = size_reg[31:0];
                state_next    = ST_IDLE;
            end
            ST_RSCAN:
            begin
                if (match_q[k_reg])
                begin
                    pos_next   = k_reg;
                    state_next = ST_REM;
                end
                else if (!blk_q[k_reg].valid || k_reg == LAST_IDX)
                begin
                    done_next     = 1'b1;
                    ok_next       = 1'b0;
                    err_next      = ERR_LIVE;
                    slot_out_next = rel_slot_reg;
                    offset_next   = '0;
                    bytes_next    = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_REM:
            begin
                cmd.op                  = OP_REMOVE;
                ram_we                  = 1'b1;
                written_next[tail_addr] = 1'b1;
                free_cnt_next           = free_cnt_reg + 1'b1;
                done_next               = 1'b1;
                ok_next                 = 1'b1;
                err_next                = ERR_NONE;
                slot_out_next           = rel_slot_reg;
                offset_next             = '0;
                bytes_next              = '0;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            free_cnt_reg <= N_CNT;
            written_reg  <= '0;
            pool_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            free_cnt_reg <= free_cnt_next;
            written_reg  <= written_next;
            done_reg     <= done_next;
            if (cfg_valid)
            begin
                pool_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        pos_reg       <= pos_next;
        cursor_reg    <= cursor_next;
        size_reg      <= size_next;
        req_slot_reg  <= req_slot_next;
        rel_slot_reg  <= rel_slot_next;
        ok_reg        <= ok_next;
        err_reg       <= err_next;
        slot_out_reg  <= slot_out_next;
        offset_reg    <= offset_next;
        bytes_reg     <= bytes_next;
        head_wr_reg   <= written_reg[head_reg];
        head_addr_reg <= head_reg;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign error_code  = err_reg;
    assign slot        = slot_out_reg;
    assign offset      = offset_reg;
    assign block_bytes = bytes_reg;

    a_ok_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok) |-> (error_code == ERR_NONE))
        else $error("successful result carries an error code");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= N_CNT)
        else $error("free slot count exceeds slot count");

    a_ins_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS) |=> (free_cnt_reg + 1'b1 == $past(free_cnt_reg)))
        else $error("insert did not pop the free slot queue");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request produced neither work nor result");

endmodule

### tb/first_fit_region_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for first_fit_region_allocator: a queued driver, a monitor and a
// predictor of the first-fit slot and offset bookkeeping. Depends on ffra_pkg and the RTL.
module first_fit_region_allocator_tb;
    import ffra_pkg::*;

    localparam int NSLOT = 64;
    localparam int ALIGN = 512;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic        action;
        logic        has_shape;
        logic [31:0] element_count;
        logic [3:0]  element_bytes;
        logic [5:0]  release_slot;
        logic        hold;
        logic        is_cfg;
        logic [31:0] cfg_value;
    } request_t;

    typedef struct {
        logic        ok;
        logic [2:0]  error_code;
        logic [5:0]  slot;
        logic [31:0] offset;
        logic [31:0] block_bytes;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic action = 1'b0;
    logic has_shape = 1'b0;
    logic [31:0] element_count = '0;
    logic [3:0] element_bytes = '0;
    logic [5:0] release_slot = '0;
    logic done, ok;
    logic [2:0] error_code;
    logic [5:0] slot;
    logic [31:0] offset, block_bytes;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;

    request_t pending_requests[$];
    grant_t   expected_grants[$];
    int error_count = 0;
    int grant_count = 0;
    int alloc_ok_count = 0;
    int idle_cycles = 0;
    bit quiet_phase = 1'b0;
    int drain_wait = 0;

    // predictor state
    logic [31:0] pool_size;
    logic [5:0]  free_fifo[NSLOT];
    int          fifo_head, free_count, live_count;
    logic [5:0]  live_list[NSLOT];
    logic [63:0] blk_offset[NSLOT];
    logic [63:0] blk_size[NSLOT];
    logic        is_live[NSLOT];

    first_fit_region_allocator #(.SLOT_COUNT(NSLOT), .ALIGN_BYTES(ALIGN)) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .has_shape(has_shape), .element_count(element_count),
        .element_bytes(element_bytes), .release_slot(release_slot), .done(done),
        .ok(ok), .error_code(error_code), .slot(slot), .offset(offset),
        .block_bytes(block_bytes), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    task automatic reset_allocator_model();
        pool_size = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            free_fifo[i] = i[5:0];
            is_live[i] = 1'b0;
        end
        fifo_head = 0;
        free_count = NSLOT;
        live_count = 0;
    endtask

    task automatic queue_request(request_t r);
        pending_requests = {pending_requests, r};
    endtask

    function automatic grant_t predict_grant(request_t r);
        grant_t g;
        logic [63:0] need, cursor, gap;
        int pos, s;
        bit found;
        g = '{1'b0, ERR_NONE, 6'd0, 32'd0, 32'd0};
        if (r.action == ACT_RELEASE)
        begin
            g.slot = r.release_slot;
            if (!is_live[r.release_slot])
            begin
                g.error_code = ERR_LIVE;
                return g;
            end
            pos = 0;
            while (live_list[pos] != r.release_slot) pos++;
            for (int k = pos; k + 1 < live_count; k++) live_list[k] = live_list[k + 1];
            live_count--;
            is_live[r.release_slot] = 1'b0;
            free_fifo[(fifo_head + free_count) % NSLOT] = r.release_slot;
            free_count++;
            g.ok = 1'b1;
            return g;
        end
        if (!r.has_shape)
        begin
            g.error_code = ERR_SHAPE;
            return g;
        end
        if (free_count == 0)
        begin
            g.error_code = ERR_SLOT;
            return g;
        end
        need = 64'(r.element_count) * 64'(r.element_bytes);
        need = ((need + ALIGN - 1) / ALIGN) * ALIGN;
        cursor = 0;
        pos = 0;
        found = 1'b0;
        for (int k = 0; k < live_count; k++)
        begin
            s = live_list[k];
            gap = (blk_offset[s] >= cursor) ? blk_offset[s] - cursor : 64'd0;
            if (gap >= need)
            begin
                found = 1'b1;
                pos = k;
                break;
            end
            cursor = blk_offset[s] + blk_size[s];
        end
        if (!found && cursor <= 64'(pool_size) && 64'(pool_size) - cursor >= need)
        begin
            found = 1'b1;
            pos = live_count;
        end
        if (!found)
        begin
            g.error_code = ERR_SPACE;
            return g;
        end
        s = free_fifo[fifo_head];
        fifo_head = (fifo_head + 1) % NSLOT;
        free_count--;
        for (int k = live_count; k > pos; k--) live_list[k] = live_list[k - 1];
        live_list[pos] = s[5:0];
        live_count++;
        is_live[s] = 1'b1;
        blk_offset[s] = cursor;
        blk_size[s] = need;
        g.ok = 1'b1;
        g.slot = s[5:0];
        g.offset = cursor[31:0];
        g.block_bytes = need[31:0];
        return g;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic request_t alloc_req(logic shape, logic [31:0] cnt, logic [3:0] eb);
        request_t r;
        r = '{ACT_ALLOC, shape, cnt, eb, 6'($urandom), 1'b0, 1'b0, 32'd0};
        return r;
    endfunction

    function automatic request_t release_req(logic [5:0] s);
        request_t r;
        r = '{ACT_RELEASE, 1'($urandom), $urandom, 4'($urandom), s, 1'b0, 1'b0, 32'd0};
        return r;
    endfunction

    function automatic request_t cfg_req(logic [31:0] v);
        request_t r;
        r = '{ACT_ALLOC, 1'b0, 32'd0, 4'd0, 6'd0, 1'b1, 1'b1, v};
        return r;
    endfunction

    // driver: a hold entry waits for an empty scoreboard and a drain pause,
    // a config entry is written only then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_valid <= 1'b0;
                pool_size = cfg_data;
                drain_wait = 0;
                pending_requests.delete(0);
            end
            else if (start && !busy)
            begin
                expected_grants = {expected_grants, predict_grant(pending_requests[0])};
                pending_requests.delete(0);
                start <= 1'b0;
            end
            else if (!start && !cfg_valid && pending_requests.size() > 0)
            begin
                if (pending_requests[0].hold)
                begin
                    if (expected_grants.size() != 0 || busy) drain_wait = 0;
                    else if (drain_wait < 150) drain_wait++;
                    else if (pending_requests[0].is_cfg)
                    begin
                        cfg_valid <= 1'b1;
                        cfg_data <= pending_requests[0].cfg_value;
                    end
                    else
                    begin
                        pending_requests[0].hold = 1'b0;
                        drain_wait = 0;
                    end
                end
                else if (quiet_phase || $urandom_range(99) >= 18)
                begin
                    action <= pending_requests[0].action;
                    has_shape <= pending_requests[0].has_shape;
                    element_count <= pending_requests[0].element_count;
                    element_bytes <= pending_requests[0].element_bytes;
                    release_slot <= pending_requests[0].release_slot;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n)
        begin
            if (done)
            begin
                grant_count++;
                if (expected_grants.size() == 0)
                begin
                    report_mismatch("result count", 32'(grant_count), 32'(grant_count - 1));
                end
                else
                begin
                    want = expected_grants[0];
                    expected_grants.delete(0);
                    if (ok !== want.ok) report_mismatch("ok", 32'(ok), 32'(want.ok));
                    if (error_code !== want.error_code)
                        report_mismatch("error_code", 32'(error_code), 32'(want.error_code));
                    if (slot !== want.slot) report_mismatch("slot", 32'(slot), 32'(want.slot));
                    if (offset !== want.offset) report_mismatch("offset", offset, want.offset);
                    if (block_bytes !== want.block_bytes)
                        report_mismatch("block_bytes", block_bytes, want.block_bytes);
                    if (want.ok && want.block_bytes != 0) alloc_ok_count++;
                end
            end
            if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding",
                         expected_grants.size());
                $display("first_fit_region_allocator_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic add_random_items(int n, int big_share);
        logic [31:0] cnt;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 45)
                queue_request(release_req(6'($urandom)));
            else
            begin
                case ($urandom_range(9))
                    0: cnt = $urandom;
                    1: cnt = 32'($urandom_range(3));
                    default: cnt = 32'($urandom_range(big_share));
                endcase
                queue_request(alloc_req($urandom_range(19) != 0, cnt,
                    4'($urandom_range(15))));
            end
        end
    endtask

    initial
    begin
        reset_allocator_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero pool, rejections, extremes, fill slots, stale release
        queue_request(alloc_req(1'b1, 32'd0, 4'd8));
        queue_request(alloc_req(1'b1, 32'd1, 4'd1));
        queue_request(cfg_req(32'hFFFF_FFFF));
        queue_request(alloc_req(1'b0, 32'd5, 4'd2));
        queue_request(alloc_req(1'b1, 32'hFFFF_FFFF, 4'd15));
        queue_request(alloc_req(1'b1, 32'hFFFF_FFFF, 4'd1));
        queue_request(alloc_req(1'b1, 32'd0, 4'd0));
        queue_request(alloc_req(1'b1, 32'd513, 4'd1));
        queue_request(release_req(6'd63));
        queue_request(release_req(6'd0));
        queue_request(alloc_req(1'b1, 32'd1, 4'd8));
        for (int i = 0; i < 64; i++) queue_request(alloc_req(1'b1, 32'd64, 4'd8));
        queue_request(alloc_req(1'b0, 32'd1, 4'd1));
        queue_request(release_req(6'd7));
        queue_request(cfg_req(32'd0));
        queue_request(alloc_req(1'b1, 32'd1, 4'd1));
        queue_request(release_req(6'd7));

        // random phases across pool sizes, ending with a pause until drained
        for (int ph = 0; ph < 6; ph++)
        begin
            queue_request(cfg_req(ph == 5 ? 32'hFFFF_FFFF : $urandom_range(65536)));
            quiet_phase = 1'b0;
            add_random_items(150, ph < 4 ? 3000 : 100000);
            queue_request(alloc_req(1'b1, 32'd0, 4'd0));
            pending_requests[$].hold = 1'b1;
        end
        while (pending_requests.size() > 450) @(posedge clk);
        quiet_phase = 1'b1;
        while (pending_requests.size() > 300) @(posedge clk);
        quiet_phase = 1'b0;
        while (pending_requests.size() > 0 || start || cfg_valid) @(posedge clk);
        while (expected_grants.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d results, %0d non-empty grants, across six pool sizes",
                 grant_count, alloc_ok_count);
        if (error_count == 0 && expected_grants.size() == 0)
            $display("first_fit_region_allocator_tb: PASS");
        else
            $display("first_fit_region_allocator_tb: FAIL");
        $finish;
    end
endmodule
